FILE: src/spq_pkg.sv
package spq_pkg;

    localparam int VAL_W = 32;
    localparam int LEN_W = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] head_value;
        logic                    is_empty;
        logic [LEN_W-1:0]        length;
        logic                    error;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

FILE: src/spq_ctrl.sv
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/spq_datapath.sv
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                    r_op;
    logic signed [VAL_W-1:0] r_value;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic signed [VAL_W-1:0] r_cell [DEPTH];
    logic signed [VAL_W-1:0] n_cell [DEPTH];
    logic [DEPTH-1:0]        gt;

    logic full;
    logic empty;
    logic do_ins;
    logic do_rem;
    logic err;

    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign do_ins = (r_op == OP_ENQ) && !full;
    assign do_rem = (r_op == OP_DEQ) && !empty;
    assign err    = (r_op == OP_ENQ) ? full : empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            // empty slots count as greater so the new value lands at the tail
            assign gt[gi] = (CW'(gi) >= r_count) || (r_cell[gi] > r_value);

            if (gi == 0) begin : g_first
                always_comb begin
                    n_cell[gi] = r_cell[gi];
                    if (do_ins && gt[gi]) begin
                        n_cell[gi] = r_value;
                    end else if (do_rem && DEPTH > 1) begin
                        n_cell[gi] = r_cell[(gi + 1) % DEPTH];
                    end
                end
            end else if (gi == DEPTH - 1) begin : g_last
                always_comb begin
                    n_cell[gi] = r_cell[gi];
                    if (do_ins && gt[gi]) begin
                        n_cell[gi] = gt[gi-1] ? r_cell[gi-1] : r_value;
                    end
                end
            end else begin : g_mid
                always_comb begin
                    n_cell[gi] = r_cell[gi];
                    if (do_ins && gt[gi]) begin
                        n_cell[gi] = gt[gi-1] ? r_cell[gi-1] : r_value;
                    end else if (do_rem) begin
                        n_cell[gi] = r_cell[gi+1];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.exec) begin
                    r_cell[gi] <= n_cell[gi];
                end
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_rem) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_in_data.opcode;
            r_value <= i_in_data.value;
        end
        if (i_cmd.exec) begin
            r_out_data.head_value <= (n_count == '0) ? '0 : n_cell[0];
            r_out_data.is_empty   <= (n_count == '0);
            r_out_data.length     <= LEN_W'(n_count);
            r_out_data.error      <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

FILE: src/sorted_priority_queue_core.sv
// Channel   Direction  Handshake                 Beat
// in        input      i_in_valid / o_in_stall   t_in_item  (opcode, value)
// out       output     o_out_valid / i_out_stall t_out_item (head_value, is_empty,
//                                                            length, error)
//
// Each item is handled in order: the beat is first captured, then the sorted
// cell row (one comparator per cell) is shifted and the output register loaded.
// The next beat is accepted while a result waits in the output register.
// A stalled output holds the shift step until the output register frees up.
// Reset (synchronous, active low) empties the queue; no clearing pass is needed.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
